[design/first_fit_graph_coloring_assert.svh]
// Assertion macros for the first-fit graph coloring block.
// Depends on nothing; included by the modules that carry checks.
`ifndef FIRST_FIT_GRAPH_COLORING_ASSERT_SVH
`define FIRST_FIT_GRAPH_COLORING_ASSERT_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside of reset.
`define FFGC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must never be seen at a clock edge outside of reset.
`define FFGC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FFGC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFGC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[design/ffgc_pkg.sv]
// Shared types, constants and the free-color search for the graph coloring block.
// Depends on nothing.
package ffgc_pkg;

	localparam int VERTEX_W         = 12;
	localparam int COLOR_W          = 7;
	localparam int COLOR_SET_W      = 64;
	localparam int DEF_MAX_VERTICES = 4096;
	localparam int DEF_MAX_COLORS   = 64;
	localparam int ADDR_SPACE       = 1 << VERTEX_W;
	localparam int MID_DEPTH        = 4;
	localparam int OUT_DEPTH        = 2;

	// One classified neighbor item on its way from the front to the back.
	typedef struct packed {
		logic [VERTEX_W-1:0] nb;
		logic                rd_valid;
		logic                last;
		logic [VERTEX_W-1:0] vertex;
	} cmd_t;

	// One finished vertex.
	typedef struct packed {
		logic [VERTEX_W-1:0] vertex;
		logic [COLOR_W-1:0]  color;
		logic                overflow;
	} res_t;

	// Smallest free color (1 based) in a 64-bit used set, 0 if all are taken.
	// Two levels of eight: first the lowest group with a hole, then the hole.
	function automatic logic [COLOR_W-1:0] first_free(input logic [COLOR_SET_W-1:0] used);
		logic [7:0]         grp_full;
		logic [2:0]         g;
		logic [2:0]         b;
		logic               found;
		logic [7:0]         row;
		logic [COLOR_W-1:0] res;
		g = '0;
		b = '0;
		found = 1'b0;
		for (int i = 0; i < 8; i++) begin
			grp_full[i] = &used[i*8 +: 8];
		end
		for (int i = 7; i >= 0; i--) begin
			if (!grp_full[i]) begin
				g = 3'(i);
				found = 1'b1;
			end
		end
		row = used[g*8 +: 8];
		for (int i = 7; i >= 0; i--) begin
			if (!row[i]) begin
				b = 3'(i);
			end
		end
		res = found ? ({1'b0, g, b} + 7'd1) : '0;
		return res;
	endfunction

endpackage

[design/ffgc_queue.sv]
// Small register queue used between the front and back and at the result side.
// Depends on nothing; width and depth come from the instantiating module.
module ffgc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots take the payload of each transfer in.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[design/ffgc_front.sv]
// Front end: takes neighbor items, tracks the current vertex and classifies each item.
// Depends on ffgc_pkg.
module ffgc_front #(
	parameter int MAX_VERTICES = ffgc_pkg::DEF_MAX_VERTICES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [ffgc_pkg::VERTEX_W-1:0] neighbor,
	input  logic                          has_neighbor,
	input  logic                          last_neighbor,
	input  logic                          last_vertex,
	input  logic                          q_full,
	output logic                          cmd_valid,
	output ffgc_pkg::cmd_t                cmd
);

	localparam int VW    = ffgc_pkg::VERTEX_W;
	localparam int DEPTH = (MAX_VERTICES < ffgc_pkg::ADDR_SPACE) ? MAX_VERTICES
	                                                              : ffgc_pkg::ADDR_SPACE;

	logic [VW-1:0] vertex_q;
	logic [VW:0]   vertex_inc;
	logic          accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	// Only neighbors below the current vertex carry a stored color.
	assign cmd.nb       = neighbor;
	assign cmd.rd_valid = has_neighbor && (neighbor < vertex_q);
	assign cmd.last     = last_neighbor;
	assign cmd.vertex   = vertex_q;

	// Items that neither name a neighbor nor close a vertex are dropped here.
	assign cmd_valid = accept && (has_neighbor || last_neighbor);

	assign vertex_inc = {1'b0, vertex_q} + 1'b1;

	// Vertex counter advances at the end of each vertex and restarts after the graph or at the vertex limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_q <= '0;
		end else if (accept && last_neighbor) begin
			if (last_vertex || (vertex_inc >= (VW+1)'(DEPTH))) begin
				vertex_q <= '0;
			end else begin
				vertex_q <= vertex_inc[VW-1:0];
			end
		end
	end

endmodule

[design/ffgc_back.sv]
// Back end: color memory lookup, used-color set and first-fit choice per vertex.
// Depends on ffgc_pkg and first_fit_graph_coloring_assert.svh.
`include "first_fit_graph_coloring_assert.svh"

module ffgc_back #(
	parameter int MAX_VERTICES = ffgc_pkg::DEF_MAX_VERTICES,
	parameter int MAX_COLORS   = ffgc_pkg::DEF_MAX_COLORS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mid_empty,
	input  ffgc_pkg::cmd_t head,
	output logic           mid_pop,
	input  logic           out_full,
	output logic           out_push,
	output ffgc_pkg::res_t res
);

	localparam int VW    = ffgc_pkg::VERTEX_W;
	localparam int CW    = ffgc_pkg::COLOR_W;
	localparam int SW    = ffgc_pkg::COLOR_SET_W;
	localparam int DEPTH = (MAX_VERTICES < ffgc_pkg::ADDR_SPACE) ? MAX_VERTICES
	                                                              : ffgc_pkg::ADDR_SPACE;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [SW-1:0] FREE_MASK = (SW'(1) << MAX_COLORS) - SW'(1);

	logic [CW-1:0]         color_mem [DEPTH];

	logic                  valid_s2;
	logic                  last_s2;
	logic                  rd_valid_s2;
	logic [VW-1:0]         vertex_s2;
	logic [CW-1:0]         rdata_s2;
	logic                  fwd_s2;
	logic [CW-1:0]         fwd_data_s2;
	logic [MAX_COLORS-1:0] used_q;

	logic                  advance;
	logic                  take;
	logic                  wr_en;
	logic [CW-1:0]         nb_color;
	logic [MAX_COLORS-1:0] mark;
	logic [MAX_COLORS-1:0] used_next;
	logic [SW-1:0]         used_pad;
	logic [CW-1:0]         pick;

	// The pipeline only holds when a finished vertex cannot leave.
	assign advance = !(valid_s2 && last_s2 && out_full);
	assign take    = advance && !mid_empty;
	assign mid_pop = take;
	assign wr_en   = valid_s2 && last_s2 && advance;

	// A color written in the same cycle as the read is forwarded.
	assign nb_color = fwd_s2 ? fwd_data_s2 : rdata_s2;

	always_comb begin
		mark = '0;
		if (valid_s2 && rd_valid_s2 && (nb_color != '0) && (nb_color <= CW'(MAX_COLORS))) begin
			mark = MAX_COLORS'(1) << (nb_color - 1'b1);
		end
	end

	// Colors beyond the configured range count as taken for the search.
	assign used_next = used_q | mark;
	assign used_pad  = SW'(used_next) | ~FREE_MASK;
	assign pick      = ffgc_pkg::first_free(used_pad);

	assign out_push     = wr_en;
	assign res.vertex   = vertex_s2;
	assign res.color    = pick;
	assign res.overflow = (pick == '0);

	// Color memory: registered read of the neighbor, write of the finished vertex.
	always_ff @(posedge clk) begin
		if (take) begin
			rdata_s2 <= color_mem[head.nb[AW-1:0]];
		end
		if (wr_en) begin
			color_mem[vertex_s2[AW-1:0]] <= pick;
		end
	end

	// Stage payload moves along with each transfer out of the middle queue.
	always_ff @(posedge clk) begin
		if (take) begin
			last_s2     <= head.last;
			rd_valid_s2 <= head.rd_valid;
			vertex_s2   <= head.vertex;
		end
		if (advance) begin
			fwd_data_s2 <= pick;
		end
	end

	// Stage control and the used-color set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			fwd_s2   <= 1'b0;
			used_q   <= '0;
		end else if (advance) begin
			valid_s2 <= take;
			fwd_s2   <= take && wr_en && (vertex_s2 == head.nb);
			if (valid_s2) begin
				used_q <= last_s2 ? '0 : used_next;
			end
		end
	end

	`FFGC_ASSERT(a_stall_holds, clk, arst_n, valid_s2 && !advance |=> valid_s2 && $stable(vertex_s2), "stalled vertex moved")
	`FFGC_ASSERT(a_fwd_set, clk, arst_n, take && wr_en && (vertex_s2 == head.nb) |=> fwd_s2, "missed color forwarding")
	`FFGC_ASSERT_NEVER(a_no_lost_result, clk, arst_n, wr_en && out_full, "result pushed into full queue")
	`FFGC_ASSERT(a_set_cleared, clk, arst_n, wr_en |=> used_q == '0, "used set not cleared after vertex")

endmodule

[design/first_fit_graph_coloring.sv]
// First-fit greedy graph coloring, top level.
// Depends on ffgc_pkg, ffgc_front, ffgc_queue and ffgc_back.
//
// Usage: vertices are colored in index order. Each vertex arrives on the input
// queue port as a run of neighbor items (push/full); the item with
// last_neighbor set closes the vertex, and last_vertex on that item restarts
// the vertex count at zero. A vertex without neighbors is one item with
// has_neighbor low and last_neighbor high.
// One result per vertex appears on the output queue port (empty/pop): the
// vertex index, its color, and overflow with color 0 when all colors are held.
// Throughput: one item per cycle while the back end is not held by a full
// result queue, set by the one color memory read and the used-color update
// done once per item in the back end. A closing item's result passes from the
// middle queue into the memory read stage, and from there into the result queue.
// Reset clears the vertex count, the used-color set and both queues; the color
// memory needs no clearing since only vertices already colored are looked up.
// When the receiver stops popping, the result queue fills, the back end holds,
// the middle queue fills and full rises; no item or result is lost.
module first_fit_graph_coloring #(
	parameter int MAX_VERTICES = ffgc_pkg::DEF_MAX_VERTICES,
	parameter int MAX_COLORS   = ffgc_pkg::DEF_MAX_COLORS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [ffgc_pkg::VERTEX_W-1:0] neighbor,
	input  logic                          has_neighbor,
	input  logic                          last_neighbor,
	input  logic                          last_vertex,
	output logic                          empty,
	input  logic                          pop,
	output logic [ffgc_pkg::VERTEX_W-1:0] vertex,
	output logic [ffgc_pkg::COLOR_W-1:0]  color_out,
	output logic                          overflow
);

	localparam int CMD_W = $bits(ffgc_pkg::cmd_t);
	localparam int RES_W = $bits(ffgc_pkg::res_t);

	logic           mid_full;
	logic           mid_empty;
	logic           mid_pop;
	logic           cmd_valid;
	ffgc_pkg::cmd_t cmd;
	ffgc_pkg::cmd_t head;
	logic           out_full;
	logic           out_push;
	ffgc_pkg::res_t res;
	ffgc_pkg::res_t res_head;

	// Front end: classification and vertex counting.
	ffgc_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.neighbor     (neighbor),
		.has_neighbor (has_neighbor),
		.last_neighbor(last_neighbor),
		.last_vertex  (last_vertex),
		.q_full       (mid_full),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd)
	);

	// Queue between front and back.
	ffgc_queue #(
		.WIDTH(CMD_W),
		.DEPTH(ffgc_pkg::MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_valid),
		.wdata (cmd),
		.full  (mid_full),
		.pop   (mid_pop),
		.empty (mid_empty),
		.rdata (head)
	);

	// Back end: color lookup and first-fit choice.
	ffgc_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_COLORS  (MAX_COLORS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.head     (head),
		.mid_pop  (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.res      (res)
	);

	// Result queue toward the receiver.
	ffgc_queue #(
		.WIDTH(RES_W),
		.DEPTH(ffgc_pkg::OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.empty (empty),
		.rdata (res_head)
	);

	assign vertex    = res_head.vertex;
	assign color_out = res_head.color;
	assign overflow  = res_head.overflow;

endmodule

[bench/first_fit_graph_coloring_test.sv]
// Testbench for first_fit_graph_coloring: queued neighbor items in, vertex colors out.
// Depends on ffgc_pkg and the first_fit_graph_coloring RTL; self-checking, no files read.
module first_fit_graph_coloring_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 880;
	localparam int CLIQUE_SIZE  = 24;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;
	localparam int LONG_HOLD    = 400;
	localparam int FIRST_HOLD   = 15;
	localparam int SECOND_HOLD  = 150;

	// One neighbor item as queued for the driver; drain_first holds it back
	// until every expected color has been received.
	typedef struct packed {
		logic                          drain_first;
		logic [ffgc_pkg::VERTEX_W-1:0] neighbor;
		logic                          has_neighbor;
		logic                          last_neighbor;
		logic                          last_vertex;
	} nb_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          full;
	logic [ffgc_pkg::VERTEX_W-1:0] neighbor = '0;
	logic                          has_neighbor = 1'b0;
	logic                          last_neighbor = 1'b0;
	logic                          last_vertex = 1'b0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic [ffgc_pkg::VERTEX_W-1:0] vertex;
	logic [ffgc_pkg::COLOR_W-1:0]  color_out;
	logic                          overflow;

	nb_item_t       pending_items[$];
	ffgc_pkg::res_t expected_colors[$];
	int             mismatches = 0;
	int             idle_cycles = 0;

	// Generator side: tracks the vertex index the next items belong to.
	int   next_vertex = 0;
	logic drain_next = 1'b0;
	int   rand_items = 0;

	// Predictor state.
	logic [ffgc_pkg::VERTEX_W-1:0]    cur_vertex = '0;
	logic [ffgc_pkg::COLOR_SET_W-1:0] used_set = '0;
	logic [ffgc_pkg::COLOR_W-1:0]     color_memory [0:ffgc_pkg::ADDR_SPACE-1];

	// Driver and receiver pacing.
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int results_seen = 0;
	int pop_mode = 0;
	int mode_left = 0;

	first_fit_graph_coloring uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Appends one item and follows the vertex count the block will see.
	task automatic add_item(input int nb, input bit has, input bit last_nb, input bit last_v);
		nb_item_t it;
		it.drain_first = drain_next;
		it.neighbor = ffgc_pkg::VERTEX_W'(nb);
		it.has_neighbor = has;
		it.last_neighbor = last_nb;
		it.last_vertex = last_v;
		pending_items.push_back(it);
		drain_next = 1'b0;
		if (last_nb) begin
			next_vertex = last_v ? 0 : (next_vertex + 1) % ffgc_pkg::ADDR_SPACE;
		end
	endtask

	task automatic add_noise();
		add_item($urandom_range(0, ffgc_pkg::ADDR_SPACE - 1), 1'b0, 1'b0, $urandom_range(0, 1));
	endtask

	// Mostly recent colored vertices, so colors climb; sometimes anything or uncolored.
	function automatic int pick_neighbor();
		int r;
		int span;
		r = $urandom_range(0, 9);
		span = (next_vertex < 12) ? next_vertex : 12;
		if (next_vertex != 0 && r < 8) begin
			return next_vertex - $urandom_range(1, span);
		end else if (r == 8) begin
			return $urandom_range(0, ffgc_pkg::ADDR_SPACE - 1);
		end else begin
			return $urandom_range(next_vertex, ffgc_pkg::ADDR_SPACE - 1);
		end
	endfunction

	task automatic build_stimulus();
		int order[$];
		int tmp;
		int k;
		int n;
		int v;
		int deg;
		bit close_alone;
		bit lastv;
		bit done;

		// Directed: isolated vertex, duplicates, uncolored and self neighbors,
		// ignored fields, last_vertex without last_neighbor, restart of the count.
		add_item(12'hFFF, 1'b0, 1'b1, 1'b0);
		add_item(0, 1'b1, 1'b1, 1'b0);
		add_item(12'hFFF, 1'b1, 1'b0, 1'b0);
		add_item(2, 1'b1, 1'b0, 1'b0);
		add_item(0, 1'b1, 1'b0, 1'b0);
		add_item(1, 1'b1, 1'b1, 1'b0);
		add_item(12'hAAA, 1'b0, 1'b0, 1'b1);
		add_item(0, 1'b1, 1'b0, 1'b0);
		add_item(1, 1'b1, 1'b0, 1'b0);
		add_item(2, 1'b1, 1'b1, 1'b0);
		add_item(0, 1'b1, 1'b0, 1'b0);
		add_item(0, 1'b1, 1'b0, 1'b1);
		add_item(3, 1'b1, 1'b1, 1'b0);
		add_item(12'h555, 1'b0, 1'b0, 1'b0);
		add_item(4, 1'b1, 1'b1, 1'b1);
		add_item(0, 1'b1, 1'b1, 1'b0);
		add_item(12'h555, 1'b0, 1'b1, 1'b0);
		add_item(1, 1'b1, 1'b1, 1'b1);

		// Clique: every vertex sees all earlier ones in shuffled order, so the
		// colors climb one by one.
		drain_next = 1'b1;
		for (k = 0; k < CLIQUE_SIZE; k++) begin
			order.delete();
			for (int i = 0; i < k; i++) begin
				order.push_back(i);
			end
			for (int i = order.size() - 1; i > 0; i--) begin
				tmp = $urandom_range(0, i);
				{order[i], order[tmp]} = {order[tmp], order[i]};
			end
			if (order.size() == 0) begin
				add_item($urandom_range(0, ffgc_pkg::ADDR_SPACE - 1), 1'b0, 1'b1, 1'b0);
			end
			for (int i = 0; i < order.size(); i++) begin
				if ($urandom_range(0, 15) == 0) add_noise();
				add_item(order[i], 1'b1, i == order.size() - 1, k == CLIQUE_SIZE - 1);
			end
		end

		// Random graphs with random content, some noise and some cut short.
		drain_next = 1'b1;
		while (rand_items < RANDOM_ITEMS) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 40);
			if ($urandom_range(0, 15) == 0) drain_next = 1'b1;
			v = 0;
			done = 1'b0;
			while (!done) begin
				deg = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
				close_alone = (deg == 0) || ($urandom_range(0, 3) == 0);
				lastv = (v == n - 1) || ($urandom_range(0, 63) == 0);
				for (int j = 0; j < deg; j++) begin
					if ($urandom_range(0, 19) == 0) add_noise();
					add_item(pick_neighbor(), 1'b1, !close_alone && j == deg - 1,
						(!close_alone && j == deg - 1) ? lastv : ($urandom_range(0, 15) == 0));
					rand_items++;
				end
				if (close_alone) begin
					add_item($urandom_range(0, ffgc_pkg::ADDR_SPACE - 1), 1'b0, 1'b1, lastv);
					rand_items++;
				end
				v++;
				done = lastv;
			end
		end
	endtask

	// Predicts the effect of one accepted item on the coloring state.
	task automatic color_vertex_item(input nb_item_t it);
		logic [ffgc_pkg::COLOR_W-1:0] c;
		logic [ffgc_pkg::COLOR_W-1:0] pick;
		ffgc_pkg::res_t r;
		if (it.has_neighbor && it.neighbor < cur_vertex) begin
			c = color_memory[it.neighbor];
			if (c >= 1 && c <= ffgc_pkg::COLOR_SET_W) used_set[c-1] = 1'b1;
		end
		if (it.last_neighbor) begin
			pick = '0;
			for (int i = ffgc_pkg::COLOR_SET_W; i >= 1; i--) begin
				if (!used_set[i-1]) pick = ffgc_pkg::COLOR_W'(i);
			end
			r.vertex = cur_vertex;
			r.color = pick;
			r.overflow = (pick == 0);
			expected_colors.push_back(r);
			color_memory[cur_vertex] = pick;
			used_set = '0;
			cur_vertex = it.last_vertex ? '0 : cur_vertex + 1'b1;
		end
	endtask

	// Sender: bursts of random length with random gaps; an offered item
	// is held until its transfer.
	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			push <= 1'b0;
			cur_vertex = '0;
			used_set = '0;
		end else if (!(push && full)) begin
			if (push) begin
				color_vertex_item(pending_items.pop_front());
				burst_left--;
				if (burst_left == 0) begin
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(20, 30);
						default: gap_left = $urandom_range(1, 6);
					endcase
				end
			end else if (gap_left > 0) begin
				gap_left--;
			end
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
			end
			go = burst_left != 0 && gap_left == 0 && pending_items.size() != 0;
			if (go && pending_items[0].drain_first && expected_colors.size() != 0) go = 1'b0;
			push <= go;
			if (go) begin
				neighbor <= pending_items[0].neighbor;
				has_neighbor <= pending_items[0].has_neighbor;
				last_neighbor <= pending_items[0].last_neighbor;
				last_vertex <= pending_items[0].last_vertex;
			end
		end
	end

	// Receiver: checks each result transfer and stalls on its own pattern,
	// with two long holds that back the block up to its input.
	always @(posedge clk or negedge arst_n) begin
		ffgc_pkg::res_t want;
		bit ready;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_colors.size() == 0) begin
					report_mismatch($sformatf("unexpected result: vertex %0d color %0d overflow %0b",
						vertex, color_out, overflow));
				end else begin
					want = expected_colors.pop_front();
					if (vertex !== want.vertex) begin
						report_mismatch($sformatf("vertex %0d, expected %0d", vertex, want.vertex));
					end
					if (color_out !== want.color) begin
						report_mismatch($sformatf("vertex %0d: color %0d, expected %0d",
							want.vertex, color_out, want.color));
					end
					if (overflow !== want.overflow) begin
						report_mismatch($sformatf("vertex %0d: overflow %0b, expected %0b",
							want.vertex, overflow, want.overflow));
					end
				end
				results_seen++;
				if (results_seen == FIRST_HOLD || results_seen == SECOND_HOLD) begin
					hold_left = LONG_HOLD;
				end
			end
			if (mode_left == 0) begin
				pop_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (pop_mode)
				0: ready = 1'b1;
				1: ready = $urandom_range(0, 3) != 0;
				2: ready = $urandom_range(0, 3) == 0;
				default: ready = (mode_left % 3) == 0;
			endcase
			if (hold_left > 0) begin
				hold_left--;
				ready = 1'b0;
			end
			pop <= ready;
		end
	end

	// Cycles since the last transfer on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		build_stimulus();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() != 0 || push) @(posedge clk);
		while (expected_colors.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/ffgc_pkg.sv
design/ffgc_queue.sv
design/ffgc_front.sv
design/ffgc_back.sv
design/first_fit_graph_coloring.sv
bench/first_fit_graph_coloring_test.sv
